/* sv/bfir_pkg.sv */
// Package with widths, tap count and the fixed band-pass coefficient table.
package bfir_pkg;

   localparam int TAP_COUNT = 129;
   localparam int COEF_LEN  = 129;
   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 13;
   localparam int PROD_W    = SAMPLE_W + COEF_W;
   localparam int ACC_W     = 36;
   localparam int SHIFT_W   = 5;
   localparam int FLAG_W    = 2;

   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd15;

   localparam logic signed [COEF_W-1:0] COEF_TABLE [0:COEF_LEN-1] = '{
         13'sd1,     13'sd3,     13'sd5,     13'sd8,     13'sd8,     13'sd5,
        -13'sd2,   -13'sd13,   -13'sd27,   -13'sd40,   -13'sd46,   -13'sd44,
       -13'sd32,   -13'sd12,    13'sd11,    13'sd32,    13'sd44,    13'sd44,
        13'sd32,    13'sd14,     13'sd0,    -13'sd2,    13'sd13,    13'sd49,
        13'sd97,   13'sd143,   13'sd170,   13'sd160,   13'sd104,     13'sd6,
      -13'sd118,  -13'sd244,  -13'sd340,  -13'sd381,  -13'sd352,  -13'sd258,
      -13'sd120,    13'sd24,   13'sd138,   13'sd192,   13'sd173,    13'sd97,
         13'sd0,   -13'sd67,   -13'sd56,    13'sd62,   13'sd287,   13'sd575,
       13'sd850,  13'sd1021,  13'sd1001,   13'sd737,   13'sd228,  -13'sd462,
     -13'sd1216, -13'sd1879, -13'sd2293, -13'sd2336, -13'sd1956, -13'sd1182,
      -13'sd133,  13'sd1008,  13'sd2030,  13'sd2736,  13'sd2988,  13'sd2736,
      13'sd2030,  13'sd1008,  -13'sd133, -13'sd1182, -13'sd1956, -13'sd2336,
     -13'sd2293, -13'sd1879, -13'sd1216,  -13'sd462,   13'sd228,   13'sd737,
      13'sd1001,  13'sd1021,   13'sd850,   13'sd575,   13'sd287,    13'sd62,
       -13'sd56,   -13'sd67,     13'sd0,    13'sd97,   13'sd173,   13'sd192,
       13'sd138,    13'sd24,  -13'sd120,  -13'sd258,  -13'sd352,  -13'sd381,
      -13'sd340,  -13'sd244,  -13'sd118,     13'sd6,   13'sd104,   13'sd160,
       13'sd170,   13'sd143,    13'sd97,    13'sd49,    13'sd13,    -13'sd2,
         13'sd0,    13'sd14,    13'sd32,    13'sd44,    13'sd44,    13'sd32,
        13'sd11,   -13'sd12,   -13'sd32,   -13'sd44,   -13'sd46,   -13'sd40,
       -13'sd27,   -13'sd13,    -13'sd2,     13'sd5,     13'sd8,     13'sd8,
         13'sd5,     13'sd3,     13'sd1
   };

   // Taps past the end of the table weigh zero.
   function automatic logic signed [COEF_W-1:0] coef_at(input int k);
      logic signed [COEF_W-1:0] c;
      c = '0;
      if (k < COEF_LEN) begin
         c = COEF_TABLE[k];
      end
      return c;
   endfunction

endpackage

/* sv/bandpass_fir_filter_core.sv */
// Top level of the streaming band-pass FIR filter: cell chain, output shift and handshakes.
// An accepted item's sum is registered in cell 0, then shifted into the output register.
// One item per cycle while results are taken; each cell's multiply-add feeds its register.
// Reset (synchronous, active high): clears all partial sums, which equals an all-zero
// delay line, empties both stages and sets shift_ff to 15. No clearing pass.
// The configuration port is always ready.
module bandpass_fir_filter_core
   import bfir_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // configuration write
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic        [SHIFT_W-1:0]  csr_data,
   // input items
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic        [FLAG_W-1:0]   req_keep_in,
   input  logic        [FLAG_W-1:0]   req_strobe_in,
   input  logic                       req_last_in,
   // result items
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_filtered_out,
   output logic        [FLAG_W-1:0]   rsp_keep_out,
   output logic        [FLAG_W-1:0]   rsp_strobe_out,
   output logic                       rsp_last_out
);

   logic                 accept;
   logic                 out_advance;

   logic [SHIFT_W-1:0]   shift_ff;
   logic [SHIFT_W-1:0]   shift_in;

   // stage 1: sum sits in cell 0, sideband sits here
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic [FLAG_W-1:0]    s1_keep_ff;
   logic [FLAG_W-1:0]    s1_strobe_ff;
   logic                 s1_last_ff;

   // stage 2: output register
   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic [SAMPLE_W-1:0]  out_data_ff;
   logic [SAMPLE_W-1:0]  out_data_in;
   logic [FLAG_W-1:0]    out_keep_ff;
   logic [FLAG_W-1:0]    out_strobe_ff;
   logic                 out_last_ff;

   logic [ACC_W-1:0]     chain [0:TAP_COUNT];
   logic signed [ACC_W-1:0] shifted;

   // Handshakes: the output register drains when empty or taken; stage 1 frees
   // whenever it moves forward, so a new item can enter every cycle unless the output stalls.
   assign out_advance = !out_valid_ff || rsp_ready;
   assign req_ready   = !s1_valid_ff || out_advance;
   assign accept      = req_valid && req_ready;
   assign csr_ready   = 1'b1;

   // Shift register for the output scaling.
   assign shift_in = (csr_valid && csr_ready) ? csr_data : shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= SHIFT_RESET;
      end else begin
         shift_ff <= shift_in;
      end
   end

   // Transposed-form chain: cell k holds the partial sum of taps k and up for
   // the items seen so far. The far end feeds in zero. All cells advance on
   // accept, so cell 0 ends up holding the full sum of the accepted item.
   assign chain[TAP_COUNT] = '0;

   for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
      bfir_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (accept),
         .sample  (req_sample_in),
         .coef    (coef_at(k)),
         .sum_in  (chain[k+1]),
         .sum_out (chain[k])
      );
   end

   // Stage 1 valid: fill on accept, drop when moved on without refill.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      priority if (accept) begin
         s1_valid_in = 1'b1;
      end else if (out_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_keep_ff   <= req_keep_in;
         s1_strobe_ff <= req_strobe_in;
         s1_last_ff   <= req_last_in;
      end
   end

   // Arithmetic shift fills with the sign of the 36-bit sum; keep the low bits.
   assign shifted     = $signed(chain[0]) >>> shift_ff;
   assign out_data_in = shifted[SAMPLE_W-1:0];

   assign out_valid_in = out_advance ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Load the output register only when a stage 1 item moves forward.
   always_ff @(posedge clock) begin
      if (out_advance && s1_valid_ff) begin
         out_data_ff   <= out_data_in;
         out_keep_ff   <= s1_keep_ff;
         out_strobe_ff <= s1_strobe_ff;
         out_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_filtered_out = out_data_ff;
   assign rsp_keep_out     = out_keep_ff;
   assign rsp_strobe_out   = out_strobe_ff;
   assign rsp_last_out     = out_last_ff;

`ifndef SYNTHESIS
   // An empty stage 1 must always take an item.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("req_ready low with stage 1 empty");

   // An accepted item is held in stage 1 next cycle.
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted item lost from stage 1");

   // A stage 1 item that moves forward shows up as a result.
   a_forward_fills_out: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_advance) |=> rsp_valid)
      else $error("stage 1 item lost on the way to the output");
`endif

endmodule

/* sv/bfir_cell.sv */
// One transposed-form filter cell: multiply by its coefficient, add the neighbor's sum.
module bfir_cell
   import bfir_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic signed [COEF_W-1:0]   coef,
   input  logic        [ACC_W-1:0]    sum_in,
   output logic        [ACC_W-1:0]    sum_out
);

   logic signed [PROD_W-1:0] prod;
   logic        [ACC_W-1:0]  part_ff;
   logic        [ACC_W-1:0]  part_in;

   assign prod    = sample * coef;
   // Sum wraps modulo 2^ACC_W.
   assign part_in = sum_in + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

   always_ff @(posedge clock) begin
      if (reset) begin
         part_ff <= '0;
      end else if (advance) begin
         part_ff <= part_in;
      end
   end

   assign sum_out = part_ff;

endmodule
